FILE: hdl/cpa_pkg.sv
package cpa_pkg;

   // Page range and the longest run that one transaction may ask for.
   localparam int TOTAL_PAGES = 1024;
   localparam int MAX_RUN     = 64;

   localparam int PAGE_W  = $clog2(TOTAL_PAGES);
   localparam int PTR_W   = PAGE_W + 1;
   localparam int COUNT_W = $clog2(MAX_RUN + 1);
   localparam int SUM_W   = ((PAGE_W > COUNT_W) ? PAGE_W : COUNT_W) + 1;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
   localparam logic [OP_W-1:0] OP_RESERVE  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

   localparam logic [PTR_W-1:0] LOWEST_PAGE_RESET = PTR_W'(1);

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN,
      FSM_MARK,
      FSM_RESP
   } fsm_type;

endpackage

FILE: hdl/contiguous_page_allocator.sv
// Channel  | Direction | Ports                                          | Handshake
// req      | in        | req_operation, req_start_page, req_page_count  | req_valid / req_stall
// rsp      | out       | rsp_status, rsp_run_start                      | rsp_valid / rsp_stall
// csr      | in        | csr_write_data (lowest_page)                   | csr_write_enable
//
// One transaction is worked on at a time; req_stall is high until the block is idle again.
// An allocate scans upward from lowest_page for a free run, then marks the run it finds, or
// answers no space if none is found: one page pointer walks the page map (single write port,
// registered read), one page per cycle, then the run is written one page per cycle.
// Free and reserve only mark their run; bad requests go straight to the response.
// After reset the page map is cleared by a pass over every page, with no request
// taken meanwhile. A finished result waits in the output register while rsp_stall is high.
module contiguous_page_allocator (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cpa_pkg::OP_W-1:0]          req_operation,
   input  logic [cpa_pkg::PAGE_W-1:0]        req_start_page,
   input  logic [cpa_pkg::COUNT_W-1:0]       req_page_count,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cpa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [cpa_pkg::PAGE_W-1:0]        rsp_run_start,

   input  logic                              csr_write_enable,
   input  logic [cpa_pkg::PTR_W-1:0]         csr_write_data
);

   // Control state.
   cpa_pkg::fsm_type                  state_ff, state_in;
   logic [cpa_pkg::PTR_W-1:0]         lowest_ff, lowest_in;
   logic [cpa_pkg::PTR_W-1:0]         scan_ptr_ff, scan_ptr_in;
   logic                              chk_valid_ff, chk_valid_in;
   logic [cpa_pkg::COUNT_W-1:0]       run_len_ff, run_len_in;
   logic [cpa_pkg::COUNT_W-1:0]       mark_left_ff, mark_left_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [cpa_pkg::PAGE_W-1:0]        chk_ptr_ff, chk_ptr_in;
   logic [cpa_pkg::PAGE_W-1:0]        mark_ptr_ff, mark_ptr_in;
   logic [cpa_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                              set_bit_ff, set_bit_in;
   logic [cpa_pkg::STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [cpa_pkg::PAGE_W-1:0]        res_index_ff, res_index_in;
   logic [cpa_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [cpa_pkg::PAGE_W-1:0]        rsp_index_ff, rsp_index_in;

   // Page map: one present bit per page, single write port, registered read.
   logic                              page_map [cpa_pkg::TOTAL_PAGES];
   logic                              rd_data_ff;
   logic [cpa_pkg::PAGE_W-1:0]        rd_addr;
   logic                              wr_en;
   logic [cpa_pkg::PAGE_W-1:0]        wr_addr;
   logic                              wr_bit;

   // Request decode.
   logic                              req_take;
   logic                              count_bad;
   logic [cpa_pkg::SUM_W-1:0]         run_end;
   logic                              run_past_end;

   // Scan datapath.
   logic                              issue;
   logic                              eval_free;
   logic [cpa_pkg::COUNT_W-1:0]       run_next;
   logic                              found;
   logic                              scan_exhausted;
   logic                              mark_last;
   logic                              clear_last;
   logic                              rsp_free;

   assign req_take     = req_valid && !req_stall;
   assign count_bad    = (req_page_count == '0) ||
                         (req_page_count > cpa_pkg::COUNT_W'(cpa_pkg::MAX_RUN));
   assign run_end      = cpa_pkg::SUM_W'(req_start_page) + cpa_pkg::SUM_W'(req_page_count);
   assign run_past_end = run_end > cpa_pkg::SUM_W'(cpa_pkg::TOTAL_PAGES);

   // The scan keeps a read in flight: the pointer issues a read while the page read in the
   // previous cycle is checked. A run of free pages grows until it reaches the asked length.
   assign issue          = scan_ptr_ff < cpa_pkg::PTR_W'(cpa_pkg::TOTAL_PAGES);
   assign eval_free      = chk_valid_ff && !rd_data_ff;
   assign run_next       = run_len_ff + cpa_pkg::COUNT_W'(1);
   assign found          = eval_free && (run_next == count_ff);
   assign scan_exhausted = !chk_valid_ff && !issue;
   assign mark_last      = mark_left_ff == cpa_pkg::COUNT_W'(1);
   assign clear_last     = scan_ptr_ff == cpa_pkg::PTR_W'(cpa_pkg::TOTAL_PAGES - 1);
   assign rsp_free       = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpa_pkg::FSM_CLEAR: begin
            if (clear_last) begin
               state_in = cpa_pkg::FSM_IDLE;
            end
         end
         cpa_pkg::FSM_IDLE: begin
            if (req_take) begin
               if (req_operation == cpa_pkg::OP_ALLOCATE && !count_bad) begin
                  state_in = cpa_pkg::FSM_SCAN;
               end else if ((req_operation == cpa_pkg::OP_FREE ||
                             req_operation == cpa_pkg::OP_RESERVE) &&
                            !count_bad && !run_past_end) begin
                  state_in = cpa_pkg::FSM_MARK;
               end else begin
                  state_in = cpa_pkg::FSM_RESP;
               end
            end
         end
         cpa_pkg::FSM_SCAN: begin
            if (found) begin
               state_in = cpa_pkg::FSM_MARK;
            end else if (scan_exhausted) begin
               state_in = cpa_pkg::FSM_RESP;
            end
         end
         cpa_pkg::FSM_MARK: begin
            if (mark_last) begin
               state_in = cpa_pkg::FSM_RESP;
            end
         end
         cpa_pkg::FSM_RESP: begin
            if (rsp_free) begin
               state_in = cpa_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = cpa_pkg::FSM_IDLE;
         end
      endcase
   end

   // Datapath and page map control.
   always_comb begin
      lowest_in     = csr_write_enable ? csr_write_data : lowest_ff;
      scan_ptr_in   = scan_ptr_ff;
      chk_valid_in  = 1'b0;
      chk_ptr_in    = chk_ptr_ff;
      run_len_in    = run_len_ff;
      mark_left_in  = mark_left_ff;
      mark_ptr_in   = mark_ptr_ff;
      count_in      = count_ff;
      set_bit_in    = set_bit_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rd_addr       = scan_ptr_ff[cpa_pkg::PAGE_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = mark_ptr_ff;
      wr_bit        = set_bit_ff;
      req_stall     = state_ff != cpa_pkg::FSM_IDLE;

      unique case (state_ff)
         cpa_pkg::FSM_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = scan_ptr_ff[cpa_pkg::PAGE_W-1:0];
            wr_bit      = 1'b0;
            scan_ptr_in = scan_ptr_ff + cpa_pkg::PTR_W'(1);
         end
         cpa_pkg::FSM_IDLE: begin
            if (req_take) begin
               count_in      = req_page_count;
               mark_left_in  = req_page_count;
               mark_ptr_in   = req_start_page;
               set_bit_in    = req_operation != cpa_pkg::OP_FREE;
               scan_ptr_in   = lowest_ff;
               run_len_in    = '0;
               res_index_in  = '0;
               res_status_in = cpa_pkg::ST_DONE;
               unique case (req_operation)
                  cpa_pkg::OP_ALLOCATE: begin
                     if (count_bad) begin
                        res_status_in = cpa_pkg::ST_RANGE;
                     end
                  end
                  cpa_pkg::OP_FREE, cpa_pkg::OP_RESERVE: begin
                     if (count_bad || run_past_end) begin
                        res_status_in = cpa_pkg::ST_RANGE;
                     end
                  end
                  default: begin
                     // The unused operation code is answered as done and leaves the map alone.
                     res_status_in = cpa_pkg::ST_DONE;
                  end
               endcase
            end
         end
         cpa_pkg::FSM_SCAN: begin
            if (issue) begin
               chk_valid_in = 1'b1;
               chk_ptr_in   = scan_ptr_ff[cpa_pkg::PAGE_W-1:0];
               scan_ptr_in  = scan_ptr_ff + cpa_pkg::PTR_W'(1);
            end
            if (chk_valid_ff) begin
               run_len_in = eval_free ? run_next : '0;
            end
            if (found) begin
               mark_ptr_in   = chk_ptr_ff - cpa_pkg::PAGE_W'(count_ff) + cpa_pkg::PAGE_W'(1);
               res_index_in  = chk_ptr_ff - cpa_pkg::PAGE_W'(count_ff) + cpa_pkg::PAGE_W'(1);
               res_status_in = cpa_pkg::ST_DONE;
               chk_valid_in  = 1'b0;
            end else if (scan_exhausted) begin
               res_status_in = cpa_pkg::ST_NO_SPACE;
               res_index_in  = '0;
            end
         end
         cpa_pkg::FSM_MARK: begin
            wr_en        = 1'b1;
            mark_ptr_in  = mark_ptr_ff + cpa_pkg::PAGE_W'(1);
            mark_left_in = mark_left_ff - cpa_pkg::COUNT_W'(1);
         end
         cpa_pkg::FSM_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpa_pkg::FSM_CLEAR;
         lowest_ff    <= cpa_pkg::LOWEST_PAGE_RESET;
         scan_ptr_ff  <= '0;
         chk_valid_ff <= 1'b0;
         run_len_ff   <= '0;
         mark_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lowest_ff    <= lowest_in;
         scan_ptr_ff  <= scan_ptr_in;
         chk_valid_ff <= chk_valid_in;
         run_len_ff   <= run_len_in;
         mark_left_ff <= mark_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ptr_ff    <= chk_ptr_in;
      mark_ptr_ff   <= mark_ptr_in;
      count_ff      <= count_in;
      set_bit_ff    <= set_bit_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   // Page map memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_map[wr_addr] <= wr_bit;
      end
      rd_data_ff <= page_map[rd_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_run_start = rsp_index_ff;

   // A new result only ever appears out of the response state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cpa_pkg::FSM_RESP))
      else $error("result raised outside the response state");

   // The marking pass always has at least one page left to write.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpa_pkg::FSM_MARK) |-> (mark_left_ff != '0))
      else $error("marking pass ran past the end of its run");

   // While scanning, the free run never reaches the asked length without leaving the scan.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpa_pkg::FSM_SCAN) |-> (run_len_ff < count_ff))
      else $error("free run overran the requested length during the scan");

endmodule
